// ===== src/htw_pkg.sv =====
// shared types, codes and helpers of the hierarchical timer wheel
package htw_pkg;

  localparam int ID_W = 6;
  localparam int MAX_RES = 8;
  localparam int RES_CW = 4;
  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // ticks covered by one slot of a level: slots to the power lvl
  function automatic logic [64:0] span_of(input int unsigned lvl, input int unsigned slots);
    logic [64:0] s;
    s = 65'd1;
    for (int unsigned i = 0; i < 9; i++) begin
      if (i < lvl) begin
        s = 65'(s * 65'(slots));
      end
    end
    return s;
  endfunction

endpackage

// ===== src/htw_ram.sv =====
// generic single write port ram with registered read
module htw_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/htw_div.sv =====
// iterative slot index unit: min(left / span(level), slots), one quotient bit a cycle
module htw_div
  import htw_pkg::*;
#(
  parameter int WHEELS = 4,
  parameter int SLOTS_PER_WHEEL = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [63:0]                           left,
  input  logic [$clog2(WHEELS)-1:0]             lvl,
  output logic                                  done,
  output logic [$clog2(SLOTS_PER_WHEEL+1)-1:0]  q
);

  localparam int LW = $clog2(WHEELS);
  localparam int CW = $clog2(SLOTS_PER_WHEEL + 1);
  localparam int QB = $clog2(SLOTS_PER_WHEEL);
  localparam int BW = (QB > 1) ? $clog2(QB) : 1;

  logic [64:0]   span_tab [WHEELS+1];
  logic          run_r;
  logic          sat_r;
  logic          done_r;
  logic [BW-1:0] b_r;
  logic [64:0]   rem_r;
  logic [CW-1:0] q_r;
  logic [LW-1:0] lvl_r;
  logic [64:0]   shifted;
  logic [LW:0]   lvl_up;

  always_comb begin
    for (int k = 0; k <= WHEELS; k++) begin
      span_tab[k] = span_of(k, SLOTS_PER_WHEEL);
    end
  end

  assign shifted = span_tab[lvl_r] << b_r;
  assign lvl_up  = {1'b0, lvl_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        sat_r <= 1'b1;
        rem_r <= {1'b0, left};
        lvl_r <= lvl;
        q_r   <= '0;
      end else if (run_r) begin
        if (sat_r) begin
          // saturate when the quotient reaches the slot count
          if (rem_r >= span_tab[lvl_up]) begin
            q_r    <= CW'(SLOTS_PER_WHEEL);
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            sat_r <= 1'b0;
            b_r   <= BW'(QB - 1);
          end
        end else begin
          if (rem_r >= shifted) begin
            rem_r    <= rem_r - shifted;
            q_r[b_r] <= 1'b1;
          end
          if (b_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            b_r <= b_r - 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== src/hierarchical_timer_wheel_unit.sv =====
// hierarchical timer wheel: sequencer, timer and slot stores, apb enable register
//
// usage
//   input channel (in_*): one request per item, opcode tick, add or delete.
//   in_stall is high from acceptance until all results of the item are handed
//   to the output register, so one request is worked on at a time.
//   result channel (out_*): add and delete give one result; a tick gives one
//   result per fired timer (at most eight reported), none if nothing fires.
//   out_last marks the final result of a request.
//   apb port: register 0 at address 0 holds enable; ticks do nothing while clear.
// work per request
//   add: one slot index run per level tried (slot index unit, one quotient
//   bit per cycle plus saturation check). delete: its work grows with each slot
//   entry scanned or shifted. tick: a walk up the levels, then per entry the
//   entry and record reads plus one slot index run per level it probes.
//   the slot index unit and the single ports of the three memories set the pace.
// reset
//   clears the tick count, cursors, active flags, slot valid bits and enable.
//   slot fill counts read as zero until written, no clearing pass.
// stall
//   a stalled output holds its result; the sequencer waits whenever it has
//   a result to hand over to a full, stalled output, and the input stays stalled meanwhile.
module hierarchical_timer_wheel_unit
  import htw_pkg::*;
#(
  parameter int WHEELS = 4,
  parameter int SLOTS_PER_WHEEL = 64,
  parameter int SLOT_CAPACITY = 8,
  parameter int TIMERS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_timer_id,
  input  logic [31:0]        in_delay,
  input  logic signed [31:0] in_repeat_count,
  input  logic [31:0]        in_repeat_interval,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_timer_id_res,
  output logic               out_status,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NSLOTS = WHEELS * SLOTS_PER_WHEEL;
  localparam int PW     = $clog2(NSLOTS);
  localparam int NENT   = NSLOTS * SLOT_CAPACITY;
  localparam int EAW    = $clog2(NENT);
  localparam int FW     = $clog2(SLOT_CAPACITY + 1);
  localparam int TAW    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int TDEPTH = (TIMERS > 1) ? TIMERS : 2;
  localparam int LW     = $clog2(WHEELS);
  localparam int CW     = $clog2(SLOTS_PER_WHEEL + 1);
  localparam int SW     = CW + 2;

  typedef struct packed {
    logic [63:0]   expiry;
    logic [31:0]   period;
    logic [31:0]   limit;
    logic [31:0]   fired;
    logic [PW-1:0] place;
  } timer_rec_t;

  localparam int RW = $bits(timer_rec_t);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_T_LVL  = 5'd1;
  localparam logic [4:0] S_T_FILL = 5'd2;
  localparam logic [4:0] S_T_ENT  = 5'd3;
  localparam logic [4:0] S_T_ID   = 5'd4;
  localparam logic [4:0] S_H_REC  = 5'd5;
  localparam logic [4:0] S_H_CMP  = 5'd6;
  localparam logic [4:0] S_H_NXT  = 5'd7;
  localparam logic [4:0] S_H_LATE = 5'd8;
  localparam logic [4:0] S_H_LEFT = 5'd9;
  localparam logic [4:0] S_H_DIR  = 5'd10;
  localparam logic [4:0] S_UP_DIV = 5'd11;
  localparam logic [4:0] S_DN_CHK = 5'd12;
  localparam logic [4:0] S_DN_DIV = 5'd13;
  localparam logic [4:0] S_PUT    = 5'd14;
  localparam logic [4:0] S_PUT_F  = 5'd15;
  localparam logic [4:0] S_A_CHK  = 5'd16;
  localparam logic [4:0] S_A_DIV  = 5'd17;
  localparam logic [4:0] S_A_EXP  = 5'd18;
  localparam logic [4:0] S_D_CHK  = 5'd19;
  localparam logic [4:0] S_D_REC  = 5'd20;
  localparam logic [4:0] S_D_FILL = 5'd21;
  localparam logic [4:0] S_D_RD   = 5'd22;
  localparam logic [4:0] S_D_CMP  = 5'd23;
  localparam logic [4:0] S_D_SH   = 5'd24;
  localparam logic [4:0] S_D_SW   = 5'd25;
  localparam logic [4:0] S_T_DONE = 5'd26;
  localparam logic [4:0] S_FIN    = 5'd27;

  // registers
  logic [4:0]        st_r, st_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [31:0]       delay_r, delay_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [31:0]       per_r, per_nxt;
  logic              en_r, en_nxt;
  logic [63:0]       tick_r, tick_nxt;
  logic [CW-1:0]     cursor_r [WHEELS];
  logic [CW-1:0]     cursor_nxt [WHEELS];
  logic [TDEPTH-1:0] active_r, active_nxt;
  logic [NSLOTS-1:0] fval_r, fval_nxt;
  logic [LW-1:0]     j_r, j_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [FW-1:0]     i_r, i_nxt;
  logic [FW-1:0]     k_r, k_nxt;
  logic [FW-1:0]     n_r, n_nxt;
  logic [PW-1:0]     slot_idx_r, slot_idx_nxt;
  logic [PW-1:0]     srv_idx_r, srv_idx_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [63:0]       left_r, left_nxt;
  timer_rec_t        rec_r, rec_nxt;
  logic [RES_CW-1:0] res_cnt_r, res_cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [1:0]        pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              pend_st_r, pend_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;

  // memory ports
  logic             e_we;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [ID_W-1:0]  e_wdata, e_rdata;
  logic             f_we;
  logic [PW-1:0]    f_waddr, f_raddr;
  logic [FW-1:0]    f_wdata, f_rdata;
  logic             t_we;
  logic [TAW-1:0]   t_waddr, t_raddr;
  timer_rec_t       t_wdata, t_rdata;
  logic [RW-1:0]    t_rbits;

  // slot index unit
  logic             div_start;
  logic [63:0]      div_left;
  logic [LW-1:0]    div_lvl;
  logic             div_done;
  logic [CW-1:0]    div_q;

  // result hand-over request
  logic             emit_req;
  logic [1:0]       emit_kind;
  logic             emit_st;

  logic [64:0]      span_tab [WHEELS+1];
  logic [TAW-1:0]   tid;
  logic             id_ok;
  logic [CW-1:0]    cur_j;
  logic [SW-1:0]    q_sum;
  logic             out_free;
  logic             can_emit;
  logic [FW-1:0]    fill_srv;
  logic [FW-1:0]    fill_put;
  logic [32:0]      fired_inc;
  logic             cfg_wr;

  htw_ram #(.W(ID_W), .D(NENT)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  htw_ram #(.W(FW), .D(NSLOTS)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  htw_ram #(.W(RW), .D(TDEPTH)) u_timers (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(RW'(t_wdata)),
    .raddr(t_raddr), .rdata(t_rbits)
  );

  assign t_rdata = timer_rec_t'(t_rbits);

  htw_div #(.WHEELS(WHEELS), .SLOTS_PER_WHEEL(SLOTS_PER_WHEEL)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .left(div_left),
    .lvl(div_lvl), .done(div_done), .q(div_q)
  );

  always_comb begin
    for (int k = 0; k <= WHEELS; k++) begin
      span_tab[k] = span_of(k, SLOTS_PER_WHEEL);
    end
  end

  assign tid       = TAW'(id_r);
  assign id_ok     = 32'(id_r) < 32'(TIMERS);
  assign cur_j     = cursor_r[j_r];
  assign q_sum     = SW'(div_q) + SW'(cur_j);
  assign out_free  = !out_valid_r || !out_stall;
  assign can_emit  = (res_cnt_r >= RES_CW'(MAX_RES)) || !pend_v_r || out_free;
  assign fill_srv  = fval_r[srv_idx_r] ? f_rdata : '0;
  assign fill_put  = fval_r[slot_idx_r] ? f_rdata : '0;
  assign fired_inc = {1'b0, rec_r.fired} + 33'd1;

  // apb register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, en_r} : 32'd0;

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    delay_nxt     = delay_r;
    cnt_nxt       = cnt_r;
    per_nxt       = per_r;
    en_nxt        = en_r;
    tick_nxt      = tick_r;
    cursor_nxt    = cursor_r;
    active_nxt    = active_r;
    fval_nxt      = fval_r;
    j_nxt         = j_r;
    lvl_nxt       = lvl_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    slot_idx_nxt  = slot_idx_r;
    srv_idx_nxt   = srv_idx_r;
    slot_nxt      = slot_r;
    left_nxt      = left_r;
    rec_nxt       = rec_r;
    res_cnt_nxt   = res_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    pend_st_nxt   = pend_st_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;

    e_we      = 1'b0;
    e_waddr   = '0;
    e_wdata   = id_r;
    e_raddr   = '0;
    f_we      = 1'b0;
    f_waddr   = slot_idx_r;
    f_wdata   = '0;
    f_raddr   = slot_idx_r;
    t_we      = 1'b0;
    t_waddr   = tid;
    t_wdata   = rec_r;
    t_raddr   = tid;
    div_start = 1'b0;
    div_left  = left_r;
    div_lvl   = j_r;
    emit_req  = 1'b0;
    emit_kind = KIND_FIRE;
    emit_st   = ST_OK;

    if (cfg_wr && paddr[2] == 1'b0) begin
      en_nxt = pwdata[0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          id_nxt      = in_timer_id;
          delay_nxt   = in_delay;
          cnt_nxt     = in_repeat_count;
          per_nxt     = (in_repeat_interval == 32'd0) ? 32'd1 : in_repeat_interval;
          res_cnt_nxt = '0;
          j_nxt       = '0;
          priority case (in_opcode)
            OP_TICK: st_nxt = en_r ? S_T_LVL : S_FIN;
            OP_ADD:  st_nxt = S_A_CHK;
            OP_DEL:  st_nxt = S_D_CHK;
            default: st_nxt = S_FIN;
          endcase
        end
      end

      // walk up past wrapped levels
      S_T_LVL: begin
        if (cur_j >= CW'(SLOTS_PER_WHEEL)) begin
          cursor_nxt[j_r] = '0;
          if (j_r == LW'(WHEELS - 1)) begin
            st_nxt = S_T_DONE;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          lvl_nxt     = j_r;
          srv_idx_nxt = PW'(32'(j_r) * 32'(SLOTS_PER_WHEEL) + 32'(cur_j));
          f_raddr     = srv_idx_nxt;
          st_nxt      = S_T_FILL;
        end
      end

      S_T_FILL: begin
        i_nxt               = fill_srv;
        fval_nxt[srv_idx_r] = 1'b0;
        st_nxt              = S_T_ENT;
      end

      // newest entry first
      S_T_ENT: begin
        if (i_r == '0) begin
          cursor_nxt[lvl_r] = cursor_r[lvl_r] + 1'b1;
          st_nxt            = S_T_DONE;
        end else begin
          e_raddr = EAW'(32'(srv_idx_r) * 32'(SLOT_CAPACITY) + 32'(i_r) - 32'd1);
          i_nxt   = i_r - 1'b1;
          st_nxt  = S_T_ID;
        end
      end

      S_T_ID: begin
        id_nxt  = e_rdata;
        t_raddr = TAW'(e_rdata);
        st_nxt  = S_H_REC;
      end

      S_H_REC: begin
        rec_nxt = t_rdata;
        st_nxt  = S_H_CMP;
      end

      S_H_CMP: begin
        if (rec_r.expiry <= tick_r) begin
          if (can_emit) begin
            emit_req      = 1'b1;
            emit_kind     = KIND_FIRE;
            rec_nxt.fired = fired_inc[31:0];
            if (rec_r.limit != FOREVER && fired_inc >= {1'b0, rec_r.limit}) begin
              active_nxt[tid] = 1'b0;
              st_nxt          = S_T_ENT;
            end else begin
              left_nxt = rec_r.expiry + 64'(rec_r.period);
              st_nxt   = S_H_NXT;
            end
          end
        end else begin
          left_nxt = rec_r.expiry - tick_r;
          if (lvl_r == '0) begin
            active_nxt[tid] = 1'b0;
            st_nxt          = S_T_ENT;
          end else begin
            j_nxt  = lvl_r - 1'b1;
            st_nxt = S_DN_CHK;
          end
        end
      end

      S_H_NXT: begin
        st_nxt = (left_r <= tick_r) ? S_H_LATE : S_H_LEFT;
      end

      // late rearm counts from now
      S_H_LATE: begin
        left_nxt = tick_r + 64'(rec_r.period);
        st_nxt   = S_H_LEFT;
      end

      S_H_LEFT: begin
        rec_nxt.expiry = left_r;
        left_nxt       = left_r - tick_r;
        j_nxt          = lvl_r;
        st_nxt         = S_H_DIR;
      end

      S_H_DIR: begin
        if ({1'b0, left_r} >= span_tab[lvl_r]) begin
          div_start = 1'b1;
          st_nxt    = S_UP_DIV;
        end else begin
          st_nxt = S_DN_CHK;
        end
      end

      // search upward for a level with room ahead of the cursor
      S_UP_DIV: begin
        if (div_done) begin
          if (q_sum + 1'b1 >= SW'(SLOTS_PER_WHEEL)) begin
            if (j_r == LW'(WHEELS - 1)) begin
              active_nxt[tid] = 1'b0;
              st_nxt          = S_T_ENT;
            end else begin
              j_nxt     = j_r + 1'b1;
              div_lvl   = j_nxt;
              div_start = 1'b1;
            end
          end else begin
            slot_nxt = q_sum;
            st_nxt   = S_PUT;
          end
        end
      end

      // search downward for the highest level whose span is reached
      S_DN_CHK: begin
        if ({1'b0, left_r} < span_tab[j_r]) begin
          j_nxt = j_r - 1'b1;
        end else begin
          div_start = 1'b1;
          st_nxt    = S_DN_DIV;
        end
      end

      S_DN_DIV: begin
        if (div_done) begin
          if (q_sum >= SW'(SLOTS_PER_WHEEL)) begin
            active_nxt[tid] = 1'b0;
            st_nxt          = S_T_ENT;
          end else begin
            slot_nxt = q_sum;
            st_nxt   = S_PUT;
          end
        end
      end

      S_PUT: begin
        slot_idx_nxt = PW'(32'(j_r) * 32'(SLOTS_PER_WHEEL) + 32'(slot_r));
        f_raddr      = slot_idx_nxt;
        st_nxt       = S_PUT_F;
      end

      S_PUT_F: begin
        if (fill_put >= FW'(SLOT_CAPACITY)) begin
          if (op_r == OP_ADD) begin
            emit_req  = 1'b1;
            emit_kind = KIND_ADD;
            emit_st   = ST_FAIL;
            st_nxt    = S_FIN;
          end else begin
            active_nxt[tid] = 1'b0;
            st_nxt          = S_T_ENT;
          end
        end else begin
          e_we                 = 1'b1;
          e_waddr              = EAW'(32'(slot_idx_r) * 32'(SLOT_CAPACITY) + 32'(fill_put));
          f_we                 = 1'b1;
          f_wdata              = fill_put + 1'b1;
          fval_nxt[slot_idx_r] = 1'b1;
          rec_nxt.place        = slot_idx_r;
          if (op_r == OP_ADD) begin
            st_nxt = S_A_EXP;
          end else begin
            t_we          = 1'b1;
            t_wdata       = rec_r;
            t_wdata.place = slot_idx_r;
            st_nxt        = S_T_ENT;
          end
        end
      end

      S_A_CHK: begin
        if (!id_ok || active_r[tid] || cnt_r == 32'd0) begin
          emit_req  = 1'b1;
          emit_kind = KIND_ADD;
          emit_st   = ST_FAIL;
          st_nxt    = S_FIN;
        end else begin
          left_nxt  = 64'(delay_r);
          div_left  = 64'(delay_r);
          div_start = 1'b1;
          st_nxt    = S_A_DIV;
        end
      end

      // lowest level whose slot index still fits
      S_A_DIV: begin
        if (div_done) begin
          if (q_sum < SW'(SLOTS_PER_WHEEL)) begin
            slot_nxt = q_sum;
            st_nxt   = S_PUT;
          end else if (j_r == LW'(WHEELS - 1)) begin
            emit_req  = 1'b1;
            emit_kind = KIND_ADD;
            emit_st   = ST_FAIL;
            st_nxt    = S_FIN;
          end else begin
            j_nxt     = j_r + 1'b1;
            div_lvl   = j_nxt;
            div_start = 1'b1;
          end
        end
      end

      S_A_EXP: begin
        t_we            = 1'b1;
        t_wdata.expiry  = tick_r + 64'(delay_r);
        t_wdata.period  = per_r;
        t_wdata.limit   = cnt_r[31] ? FOREVER : cnt_r;
        t_wdata.fired   = '0;
        t_wdata.place   = rec_r.place;
        active_nxt[tid] = 1'b1;
        emit_req        = 1'b1;
        emit_kind       = KIND_ADD;
        emit_st         = ST_OK;
        st_nxt          = S_FIN;
      end

      S_D_CHK: begin
        if (!id_ok || !active_r[tid]) begin
          emit_req  = 1'b1;
          emit_kind = KIND_DEL;
          emit_st   = ST_FAIL;
          st_nxt    = S_FIN;
        end else begin
          st_nxt = S_D_REC;
        end
      end

      S_D_REC: begin
        slot_idx_nxt = t_rdata.place;
        f_raddr      = t_rdata.place;
        st_nxt       = S_D_FILL;
      end

      S_D_FILL: begin
        n_nxt  = fill_put;
        i_nxt  = '0;
        st_nxt = S_D_RD;
      end

      S_D_RD: begin
        if (i_r == n_r) begin
          emit_req  = 1'b1;
          emit_kind = KIND_DEL;
          emit_st   = ST_FAIL;
          st_nxt    = S_FIN;
        end else begin
          e_raddr = EAW'(32'(slot_idx_r) * 32'(SLOT_CAPACITY) + 32'(i_r));
          st_nxt  = S_D_CMP;
        end
      end

      S_D_CMP: begin
        if (e_rdata == id_r) begin
          k_nxt  = i_r;
          st_nxt = S_D_SH;
        end else begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_D_RD;
        end
      end

      // close the gap, one entry a step
      S_D_SH: begin
        if ((k_r + 1'b1) < n_r) begin
          e_raddr = EAW'(32'(slot_idx_r) * 32'(SLOT_CAPACITY) + 32'(k_r) + 32'd1);
          st_nxt  = S_D_SW;
        end else begin
          f_we            = 1'b1;
          f_wdata         = n_r - 1'b1;
          active_nxt[tid] = 1'b0;
          emit_req        = 1'b1;
          emit_kind       = KIND_DEL;
          emit_st         = ST_OK;
          st_nxt          = S_FIN;
        end
      end

      S_D_SW: begin
        e_we    = 1'b1;
        e_waddr = EAW'(32'(slot_idx_r) * 32'(SLOT_CAPACITY) + 32'(k_r));
        e_wdata = e_rdata;
        k_nxt   = k_r + 1'b1;
        st_nxt  = S_D_SH;
      end

      S_T_DONE: begin
        tick_nxt = tick_r + 64'd1;
        st_nxt   = S_FIN;
      end

      S_FIN: begin
        if (!pend_v_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_id_nxt    = pend_id_r;
          out_st_nxt    = pend_st_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // one result held back so the final one can carry last
    if (emit_req && res_cnt_r < RES_CW'(MAX_RES)) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_id_nxt    = pend_id_r;
        out_st_nxt    = pend_st_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_id_nxt   = id_r;
      pend_st_nxt   = emit_st;
      res_cnt_nxt   = res_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      en_r        <= 1'b0;
      tick_r      <= '0;
      active_r    <= '0;
      fval_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      res_cnt_r   <= '0;
      for (int w = 0; w < WHEELS; w++) begin
        cursor_r[w] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      en_r        <= en_nxt;
      tick_r      <= tick_nxt;
      active_r    <= active_nxt;
      fval_r      <= fval_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      res_cnt_r   <= res_cnt_nxt;
      cursor_r    <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    delay_r     <= delay_nxt;
    cnt_r       <= cnt_nxt;
    per_r       <= per_nxt;
    j_r         <= j_nxt;
    lvl_r       <= lvl_nxt;
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    slot_idx_r  <= slot_idx_nxt;
    srv_idx_r   <= srv_idx_nxt;
    slot_r      <= slot_nxt;
    left_r      <= left_nxt;
    rec_r       <= rec_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_st_r   <= pend_st_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall         = (st_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_timer_id_res = out_id_r;
  assign out_status       = out_st_r;
  assign out_last         = out_last_r;

endmodule

// ===== bench/hierarchical_timer_wheel_checker.sv =====
// checker for the timer wheel: request and result monitors, timer wheel predictor, scoreboard
module hierarchical_timer_wheel_checker
  import htw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_timer_id,
  input  logic [31:0]        in_delay,
  input  logic signed [31:0] in_repeat_count,
  input  logic [31:0]        in_repeat_interval,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_kind,
  input  logic [5:0]         out_timer_id_res,
  input  logic               out_status,
  input  logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_results
);

  localparam int LEVELS = 4;
  localparam int SLOTS = 64;
  localparam int CAP = 8;
  localparam int NTIMERS = 64;
  localparam logic [2:0] ADDR_ENABLE = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] id;
    logic       status;
    logic       last;
  } wheel_result_t;

  wheel_result_t result_q[$];
  wheel_result_t item_res[MAX_RES];
  int            item_n;

  logic        wheel_enable;
  logic [63:0] tick_now;
  int unsigned cursor[LEVELS];
  logic [5:0]  slot_ids[LEVELS*SLOTS][CAP];
  int unsigned fill[LEVELS*SLOTS];
  logic [63:0] expiry[NTIMERS];
  logic [31:0] period[NTIMERS];
  logic [31:0] limit[NTIMERS];
  logic [31:0] fired[NTIMERS];
  bit          active[NTIMERS];
  int unsigned place[NTIMERS];

  function automatic logic [63:0] level_span(int lvl);
    return 64'd1 << (6 * lvl);
  endfunction

  // slot a remaining time lands in, quotient saturated at the wheel size
  function automatic logic [63:0] slot_index(int lvl, logic [63:0] left);
    logic [63:0] q;
    q = left / level_span(lvl);
    if (q > SLOTS) q = SLOTS;
    return q + 64'(cursor[lvl]);
  endfunction

  function automatic bit slot_insert(int lvl, logic [63:0] slot, logic [5:0] id);
    int unsigned idx;
    if (slot >= SLOTS) return 0;
    idx = lvl * SLOTS + int'(slot);
    if (fill[idx] >= CAP) return 0;
    slot_ids[idx][fill[idx]] = id;
    fill[idx]++;
    place[id] = idx;
    return 1;
  endfunction

  function automatic void note_result(logic [1:0] kind, logic [5:0] id, logic status);
    if (item_n >= MAX_RES) return;
    item_res[item_n] = '{kind: kind, id: id, status: status, last: 1'b0};
    item_n++;
  endfunction

  // one entry taken from a served slot: fire and rearm or retire, or move down
  function automatic void serve_entry(logic [5:0] id, int lvl, logic [63:0] now);
    logic [63:0] nxt, left;
    int j;
    if (expiry[id] <= now) begin
      note_result(KIND_FIRE, id, ST_OK);
      fired[id]++;
      if (limit[id] != FOREVER && fired[id] >= limit[id]) begin
        active[id] = 0;
        return;
      end
      nxt = expiry[id] + 64'(period[id]);
      if (nxt <= now) nxt = now + 64'(period[id]);
      expiry[id] = nxt;
      left = nxt - now;
      j = lvl;
      if (left >= level_span(lvl)) begin
        while (j < LEVELS && slot_index(j, left) + 1 >= SLOTS) j++;
      end else begin
        while (j >= 0 && left < level_span(j)) j--;
      end
    end else begin
      left = expiry[id] - now;
      j = lvl - 1;
      while (j >= 0 && left < level_span(j)) j--;
    end
    if (j < 0 || j >= LEVELS) active[id] = 0;
    else if (!slot_insert(j, slot_index(j, left), id)) active[id] = 0;
  endfunction

  function automatic void advance_wheels(logic [63:0] now);
    int lvl;
    int unsigned idx, n, cur;
    logic [5:0] held[CAP];
    lvl = 0;
    while (cursor[lvl] >= SLOTS) begin
      cursor[lvl] = 0;
      lvl++;
      if (lvl >= LEVELS) return;
    end
    cur = cursor[lvl];
    idx = lvl * SLOTS + cur;
    n = fill[idx];
    for (int i = 0; i < CAP; i++) held[i] = slot_ids[idx][i];
    fill[idx] = 0;
    for (int i = int'(n) - 1; i >= 0; i--) serve_entry(held[i], lvl, now);
    cursor[lvl] = cur + 1;
  endfunction

  function automatic logic add_timer(logic [5:0] id, logic [31:0] dly, logic [31:0] cnt,
                                     logic [31:0] per);
    int lvl;
    logic [63:0] slot;
    if (active[id] || cnt == 0) return ST_FAIL;
    if (per == 0) per = 1;
    lvl = -1;
    slot = 0;
    for (int j = 0; j < LEVELS; j++) begin
      slot = slot_index(j, 64'(dly));
      if (slot < SLOTS) begin
        lvl = j;
        break;
      end
    end
    if (lvl < 0) return ST_FAIL;
    if (!slot_insert(lvl, slot, id)) return ST_FAIL;
    expiry[id] = tick_now + 64'(dly);
    period[id] = per;
    limit[id] = cnt[31] ? FOREVER : cnt;
    fired[id] = 0;
    active[id] = 1;
    return ST_OK;
  endfunction

  function automatic logic delete_timer(logic [5:0] id);
    int unsigned idx, n;
    if (!active[id]) return ST_FAIL;
    idx = place[id];
    n = fill[idx];
    for (int i = 0; i < int'(n); i++) begin
      if (slot_ids[idx][i] == id) begin
        for (int k = i; k < int'(n) - 1; k++) slot_ids[idx][k] = slot_ids[idx][k+1];
        fill[idx] = n - 1;
        active[id] = 0;
        return ST_OK;
      end
    end
    return ST_FAIL;
  endfunction

  always @(posedge clk) begin
    wheel_result_t got, want;
    if (!rst_n) begin
      wheel_enable = 0;
      tick_now = 0;
      for (int i = 0; i < LEVELS; i++) cursor[i] = 0;
      for (int i = 0; i < LEVELS*SLOTS; i++) fill[i] = 0;
      for (int i = 0; i < NTIMERS; i++) active[i] = 0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      // enable register write at the access phase
      if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE)
        wheel_enable = pwdata[0];

      // accepted request: predict its results
      if (in_valid && !in_stall) begin
        item_n = 0;
        case (in_opcode)
          OP_TICK: begin
            if (wheel_enable) begin
              advance_wheels(tick_now);
              tick_now = tick_now + 1;
            end
          end
          OP_ADD: note_result(KIND_ADD, in_timer_id,
                              add_timer(in_timer_id, in_delay, in_repeat_count,
                                        in_repeat_interval));
          OP_DEL: note_result(KIND_DEL, in_timer_id, delete_timer(in_timer_id));
          default: ;
        endcase
        if (item_n > 0) item_res[item_n-1].last = 1'b1;
        for (int i = 0; i < item_n; i++) result_q.push_back(item_res[i]);
      end

      // accepted result: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{kind: out_kind, id: out_timer_id_res, status: out_status, last: out_last};
        if (result_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: kind %0d id %0d status %0d last %0d",
                     got.kind, got.id, got.status, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("result mismatch: expected kind %0d id %0d status %0d last %0d, got kind %0d id %0d status %0d last %0d",
                       want.kind, want.id, want.status, want.last,
                       got.kind, got.id, got.status, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_results <= result_q.size();
  end

endmodule

// ===== bench/hierarchical_timer_wheel_unit_test.sv =====
// top of the timer wheel testbench: clock, reset, stimulus and verdict
module hierarchical_timer_wheel_unit_test;
  import htw_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 600;   // longest tick walk with no result
  localparam int PHASE_ITEMS = 65;
  localparam logic [2:0] ADDR_ENABLE = 3'd0;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_opcode = OP_TICK;
  logic [5:0]         in_timer_id = 0;
  logic [31:0]        in_delay = 0;
  logic signed [31:0] in_repeat_count = 0;
  logic [31:0]        in_repeat_interval = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         out_kind;
  logic [5:0]         out_timer_id_res;
  logic               out_status;
  logic               out_last;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls

  hierarchical_timer_wheel_unit uut (.*);

  hierarchical_timer_wheel_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_timer_id, .in_delay,
    .in_repeat_count, .in_repeat_interval, .out_valid, .out_stall, .out_kind,
    .out_timer_id_res, .out_status, .out_last, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata, .fail_count, .pending_results
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver side: random stall at the configured rate
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request: optional random hold-off, then wait for acceptance
  task automatic send_request(logic [1:0] op, logic [5:0] id, logic [31:0] dly,
                              logic [31:0] cnt, logic [31:0] per);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_timer_id <= id;
    in_delay <= dly;
    in_repeat_count <= cnt;
    in_repeat_interval <= per;
    do @(posedge clk); while (in_stall);
  endtask

  // apb write of the enable register, setup then access cycle
  task automatic write_enable(logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ENABLE;
    pwdata <= {$urandom} & ~32'h1 | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // let every predicted result arrive, then give a silent tick time to finish
  task automatic drain;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random request, mostly short delays and counts so timers fire and rearm
  task automatic random_request;
    int pick;
    logic [1:0]  op;
    logic [31:0] dly, cnt, per;
    pick = $urandom_range(99);
    op = pick < 50 ? OP_TICK : pick < 85 ? OP_ADD : pick < 97 ? OP_DEL : 2'd3;
    pick = $urandom_range(99);
    dly = pick < 70 ? $urandom_range(200) : pick < 90 ? $urandom_range(300000) : $urandom;
    pick = $urandom_range(99);
    cnt = pick < 5 ? 0 : pick < 25 ? 32'hFFFF_FFFF : pick < 85 ? $urandom_range(1, 4)
        : $urandom;
    per = $urandom_range(99) < 90 ? $urandom_range(50) : $urandom;
    send_request(op, 6'($urandom_range(63)), dly, cnt, per);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick while disabled, then the add and delete corner cases
    send_request(OP_TICK, 0, 0, 0, 0);
    drain();
    write_enable(1'b1);
    send_request(OP_ADD, 0, 0, 1, 0);                         // zero delay, zero interval
    send_request(OP_TICK, 0, 0, 0, 0);
    send_request(OP_ADD, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // fits no level
    send_request(OP_ADD, 63, 5, 0, 7);                        // zero count
    send_request(OP_ADD, 2, 70, 32'h7FFF_FFFF, 1);
    send_request(OP_ADD, 2, 1, 1, 1);                         // id already active
    send_request(OP_DEL, 63, 0, 0, 0);                        // not active
    send_request(OP_DEL, 2, 0, 0, 0);
    send_request(2'd3, 5, 0, 0, 0);                           // unknown opcode
    for (int i = 10; i < 19; i++)
      send_request(OP_ADD, 6'(i), 2, 32'hFFFF_FFFF, 3);       // ninth finds the slot full
    repeat (3) send_request(OP_TICK, 0, 0, 0, 0);             // eight fire in one tick
    send_request(OP_ADD, 20, 100000, 3, 0);                   // upper level
    send_request(OP_DEL, 10, 0, 0, 0);
    send_request(OP_TICK, 0, 0, 0, 0);
    drain();

    // random phases with different idle patterns and enable settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_enable(1'b1); end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  write_enable(1'b0); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; write_enable(1'b1); end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; write_enable(1'b1); end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/htw_pkg.sv
src/htw_ram.sv
src/htw_div.sv
src/hierarchical_timer_wheel_unit.sv
bench/hierarchical_timer_wheel_checker.sv
bench/hierarchical_timer_wheel_unit_test.sv
